### rtl/core/swl_pkg.sv
// Shared constants, types and arithmetic helpers of the shallow-water stencil block.
`default_nettype none

package swl_pkg;

    localparam int COLS      = 64;
    localparam int ROWS      = 64;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = COLS * ROWS;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLS);

    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int COEF_W    = 16;
    localparam int OP_W      = 2;
    localparam int CELL_IN_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam int ALU_OPS   = 20;
    localparam int STEP_W    = $clog2(ALU_OPS);

    localparam logic [COEF_W-1:0] X_ADVECT_RESET  = 16'd101;
    localparam logic [COEF_W-1:0] Y_ADVECT_RESET  = 16'd101;
    localparam logic [COEF_W-1:0] X_GRAVITY_RESET = 16'd990;
    localparam logic [COEF_W-1:0] Y_GRAVITY_RESET = 16'd990;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ADVECT  = 2'd0,
        CFG_Y_ADVECT  = 2'd1,
        CFG_X_GRAVITY = 2'd2,
        CFG_Y_GRAVITY = 2'd3
    } cfg_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CELL_LOAD,
        ST_CELL_CALC,
        ST_EDGE_LOAD,
        ST_EDGE_WB
    } state_t;

    typedef enum logic [2:0] {
        ACT_T_SET,
        ACT_T_HALF_SET,
        ACT_T_HALF_SUB,
        ACT_ACC_U,
        ACT_ACC_V,
        ACT_ACC_H
    } act_t;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        word_t u;
        word_t v;
        word_t h;
        word_t b;
    } cell_t;

    typedef struct packed {
        cell_t c;
        cell_t e;
        cell_t w;
        cell_t n;
        cell_t s;
    } stencil_t;

    typedef struct packed {
        logic [COEF_W-1:0] ax;
        logic [COEF_W-1:0] ay;
        logic [COEF_W-1:0] gx;
        logic [COEF_W-1:0] gy;
    } coef_t;

    function automatic word_t sat32(input wide_t x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[DATA_W-1:0];
    endfunction

    // Edge value (5a - 4b + c) / 2, rounded toward minus infinity.
    function automatic word_t extrap(input word_t a, input word_t b, input word_t c);
        wide_t s;
        s = (wide_t'(a) <<< 2) + wide_t'(a) - (wide_t'(b) <<< 2) + wide_t'(c);
        return sat32(s >>> 1);
    endfunction

endpackage

`default_nettype wire

### rtl/core/swl_if.sv
// Command and response channel interfaces of the shallow-water stencil block.
`default_nettype none

interface swl_in_if;
    logic                               valid;
    logic                               ready;
    logic [swl_pkg::OP_W-1:0]           operation;
    logic [swl_pkg::CELL_IN_W-1:0]      cell_index;
    logic signed [swl_pkg::DATA_W-1:0]  u_in;
    logic signed [swl_pkg::DATA_W-1:0]  v_in;
    logic signed [swl_pkg::DATA_W-1:0]  h_in;
    logic signed [swl_pkg::DATA_W-1:0]  b_in;

    modport source (output valid, operation, cell_index, u_in, v_in, h_in, b_in,
                    input ready);
    modport sink (input valid, operation, cell_index, u_in, v_in, h_in, b_in,
                  output ready);
endinterface

interface swl_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [swl_pkg::DATA_W-1:0]  u_out;
    logic signed [swl_pkg::DATA_W-1:0]  v_out;
    logic signed [swl_pkg::DATA_W-1:0]  h_out;

    modport source (output valid, u_out, v_out, h_out, input ready);
    modport sink (input valid, u_out, v_out, h_out, output ready);
endinterface

`default_nettype wire

### rtl/core/swl_grid_mem.sv
// Grid storage: two levels of u, v and h plus one bed level, one read and one write port.
`default_nettype none

module swl_grid_mem (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [swl_pkg::ADDR_W-1:0]   rd_addr,
    input  wire logic                         wr_uvh,
    input  wire logic                         wr_bed,
    input  wire logic [swl_pkg::ADDR_W-1:0]   wr_addr,
    input  wire swl_pkg::cell_t               wr_data,
    output swl_pkg::cell_t                    rd_data
);

    swl_pkg::word_t u_mem   [0:(1 << swl_pkg::ADDR_W)-1];
    swl_pkg::word_t v_mem   [0:(1 << swl_pkg::ADDR_W)-1];
    swl_pkg::word_t h_mem   [0:(1 << swl_pkg::ADDR_W)-1];
    swl_pkg::word_t bed_mem [0:(1 << swl_pkg::IDX_W)-1];

    swl_pkg::cell_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_uvh)
        begin
            u_mem[wr_addr] <= wr_data.u;
            v_mem[wr_addr] <= wr_data.v;
            h_mem[wr_addr] <= wr_data.h;
        end
        if (wr_bed)
        begin
            bed_mem[wr_addr[swl_pkg::IDX_W-1:0]] <= wr_data.b;
        end
    end

    // The bed has one level, so the bank bit of the address is dropped for it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.u <= u_mem[rd_addr];
            rd_data_reg.v <= v_mem[rd_addr];
            rd_data_reg.h <= h_mem[rd_addr];
            rd_data_reg.b <= bed_mem[rd_addr[swl_pkg::IDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/swl_flux_unit.sv
// Interior cell update: one shared multiplier stepped through the twenty flux products.
`default_nettype none

module swl_flux_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire swl_pkg::stencil_t  st,
    input  wire swl_pkg::coef_t     coef,
    output logic                    done,
    output swl_pkg::word_t          u_new,
    output swl_pkg::word_t          v_new,
    output swl_pkg::word_t          h_new
);

    logic                        busy_reg;
    logic                        phase_reg;
    logic [swl_pkg::STEP_W-1:0]  op_reg;
    logic                        done_reg;

    swl_pkg::word_t uc_reg, ue_reg, uw_reg, vc_reg, vn_reg, vs_reg;
    swl_pkg::word_t u_ns_reg, h_ew_reg, v_ew_reg, h_ns_reg;
    swl_pkg::word_t d_ew_reg, d_ns_reg, u_ew_reg, v_ns_reg, d_c_reg;
    swl_pkg::wide_t acc_u_reg, acc_v_reg, acc_h_reg, t_reg, prod_reg;

    swl_pkg::word_t a_sel, b_sel, t_sat, ax_w, ay_w, gx_w, gy_w;
    swl_pkg::act_t  act;
    swl_pkg::wide_t q;

    localparam int PAD_W = swl_pkg::DATA_W - swl_pkg::COEF_W;

    assign ax_w  = {{PAD_W{1'b0}}, coef.ax};
    assign ay_w  = {{PAD_W{1'b0}}, coef.ay};
    assign gx_w  = {{PAD_W{1'b0}}, coef.gx};
    assign gy_w  = {{PAD_W{1'b0}}, coef.gy};
    assign t_sat = swl_pkg::sat32(t_reg);
    assign q     = prod_reg >>> swl_pkg::FRAC_BITS;

    // Step program: operands of each product and where its scaled result goes.
    always_comb
    begin
        a_sel = '0;
        b_sel = '0;
        act   = swl_pkg::ACT_T_SET;
        case (op_reg)
            5'd0:  begin a_sel = ue_reg; b_sel = ue_reg;   act = swl_pkg::ACT_T_HALF_SET; end
            5'd1:  begin a_sel = uw_reg; b_sel = uw_reg;   act = swl_pkg::ACT_T_HALF_SUB; end
            5'd2:  begin a_sel = ax_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_U;      end
            5'd3:  begin a_sel = vc_reg; b_sel = u_ns_reg; act = swl_pkg::ACT_T_SET;      end
            5'd4:  begin a_sel = ay_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_U;      end
            5'd5:  begin a_sel = gx_w;   b_sel = h_ew_reg; act = swl_pkg::ACT_ACC_U;      end
            5'd6:  begin a_sel = vn_reg; b_sel = vn_reg;   act = swl_pkg::ACT_T_HALF_SET; end
            5'd7:  begin a_sel = vs_reg; b_sel = vs_reg;   act = swl_pkg::ACT_T_HALF_SUB; end
            5'd8:  begin a_sel = ay_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_V;      end
            5'd9:  begin a_sel = uc_reg; b_sel = v_ew_reg; act = swl_pkg::ACT_T_SET;      end
            5'd10: begin a_sel = ax_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_V;      end
            5'd11: begin a_sel = gy_w;   b_sel = h_ns_reg; act = swl_pkg::ACT_ACC_V;      end
            5'd12: begin a_sel = uc_reg; b_sel = d_ew_reg; act = swl_pkg::ACT_T_SET;      end
            5'd13: begin a_sel = ax_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_H;      end
            5'd14: begin a_sel = vc_reg; b_sel = d_ns_reg; act = swl_pkg::ACT_T_SET;      end
            5'd15: begin a_sel = ay_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_H;      end
            5'd16: begin a_sel = d_c_reg; b_sel = u_ew_reg; act = swl_pkg::ACT_T_SET;     end
            5'd17: begin a_sel = ax_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_H;      end
            5'd18: begin a_sel = d_c_reg; b_sel = v_ns_reg; act = swl_pkg::ACT_T_SET;     end
            5'd19: begin a_sel = ay_w;   b_sel = t_sat;    act = swl_pkg::ACT_ACC_H;      end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            op_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                op_reg    <= '0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    if (op_reg == swl_pkg::STEP_W'(swl_pkg::ALU_OPS - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        op_reg <= op_reg + swl_pkg::STEP_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            uc_reg   <= st.c.u;
            ue_reg   <= st.e.u;
            uw_reg   <= st.w.u;
            vc_reg   <= st.c.v;
            vn_reg   <= st.n.v;
            vs_reg   <= st.s.v;
            u_ns_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.n.u) - swl_pkg::wide_t'(st.s.u));
            u_ew_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.e.u) - swl_pkg::wide_t'(st.w.u));
            v_ew_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.e.v) - swl_pkg::wide_t'(st.w.v));
            v_ns_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.n.v) - swl_pkg::wide_t'(st.s.v));
            h_ew_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.e.h) - swl_pkg::wide_t'(st.w.h));
            h_ns_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.n.h) - swl_pkg::wide_t'(st.s.h));
            d_c_reg  <= swl_pkg::sat32(swl_pkg::wide_t'(st.c.h) - swl_pkg::wide_t'(st.c.b));
            d_ew_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.e.h) - swl_pkg::wide_t'(st.e.b)
                                     - swl_pkg::wide_t'(st.w.h) + swl_pkg::wide_t'(st.w.b));
            d_ns_reg <= swl_pkg::sat32(swl_pkg::wide_t'(st.n.h) - swl_pkg::wide_t'(st.n.b)
                                     - swl_pkg::wide_t'(st.s.h) + swl_pkg::wide_t'(st.s.b));
            acc_u_reg <= (swl_pkg::wide_t'(st.e.u) + swl_pkg::wide_t'(st.w.u)
                        + swl_pkg::wide_t'(st.n.u) + swl_pkg::wide_t'(st.s.u)) >>> 2;
            acc_v_reg <= (swl_pkg::wide_t'(st.e.v) + swl_pkg::wide_t'(st.w.v)
                        + swl_pkg::wide_t'(st.n.v) + swl_pkg::wide_t'(st.s.v)) >>> 2;
            acc_h_reg <= (swl_pkg::wide_t'(st.e.h) + swl_pkg::wide_t'(st.w.h)
                        + swl_pkg::wide_t'(st.n.h) + swl_pkg::wide_t'(st.s.h)) >>> 2;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                prod_reg <= swl_pkg::wide_t'(a_sel) * swl_pkg::wide_t'(b_sel);
            end
            else
            begin
                case (act)
                    swl_pkg::ACT_T_SET:      t_reg     <= q;
                    swl_pkg::ACT_T_HALF_SET: t_reg     <= q >>> 1;
                    swl_pkg::ACT_T_HALF_SUB: t_reg     <= t_reg - (q >>> 1);
                    swl_pkg::ACT_ACC_U:      acc_u_reg <= acc_u_reg - q;
                    swl_pkg::ACT_ACC_V:      acc_v_reg <= acc_v_reg - q;
                    swl_pkg::ACT_ACC_H:      acc_h_reg <= acc_h_reg - q;
                    default: ;
                endcase
            end
        end
    end

    assign done  = done_reg;
    assign u_new = swl_pkg::sat32(acc_u_reg);
    assign v_new = swl_pkg::sat32(acc_v_reg);
    assign h_new = swl_pkg::sat32(acc_h_reg);

endmodule

`default_nettype wire

### rtl/core/shallow_water_lax_stencil_step.sv
// Top level: command decode, sweep sequencer, edge extrapolation and result register.
//
//  channel | dir | handshake         | beat
//  cmd     | in  | valid/ready       | operation, cell_index, u_in, v_in, h_in, b_in
//  rsp     | out | valid/ready       | u_out, v_out, h_out (read commands only)
//  cfg     | in  | cfg_we, no ready  | cfg_index, cfg_data
//
// A read beat is read into the memory's read register, then loaded into the result
// register. A step beat holds cmd.ready low for the sweep: five stencil reads per
// interior cell on the single read port, then twenty products on the one shared
// multiplier, and three reads per edge cell. Levels swap by a bank bit, so no copy pass
// follows. Reset clears control and loads the coefficient defaults; grid contents are
// undefined until written. A stalled result holds in the register.
`default_nettype none

module shallow_water_lax_stencil_step (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    swl_in_if.sink                               cmd,
    swl_out_if.source                            rsp,
    input  wire logic                            cfg_we,
    input  wire logic [swl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swl_pkg::COEF_W-1:0]      cfg_data
);

    localparam int IW = swl_pkg::IDX_W;

    swl_pkg::state_t              state_reg, state_next;
    logic                         bank_reg, bank_next;
    logic [IW-1:0]                k_reg, k_next;
    logic [swl_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [swl_pkg::COL_W-1:0]    col_reg, col_next;
    logic [2:0]                   ld_reg, ld_next;
    logic                         side_reg, side_next;
    logic                         row_pass_reg, row_pass_next;
    logic [IW-1:0]                ptr_reg, ptr_next;
    logic                         oob_reg, oob_next;
    logic                         alu_start_reg, alu_start_next;
    logic                         out_valid_reg;
    swl_pkg::word_t               u_out_reg, v_out_reg, h_out_reg;
    swl_pkg::coef_t               coef_reg;
    swl_pkg::cell_t               slot_reg [5];

    logic                         accept, in_grid, out_load, slot_shift;
    logic [IW-1:0]                cmd_idx, nbr_addr, tgt, stride, edge_addr;
    logic                         mem_rd_en, mem_wr_uvh, mem_wr_bed;
    logic [swl_pkg::ADDR_W-1:0]   mem_rd_addr, mem_wr_addr;
    swl_pkg::cell_t               mem_wr_data, mem_rd_data;
    swl_pkg::stencil_t            st;
    logic                         alu_done;
    swl_pkg::word_t               u_new, v_new, h_new;

    swl_grid_mem u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_uvh  (mem_wr_uvh),
        .wr_bed  (mem_wr_bed),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign st = '{c: slot_reg[0], e: slot_reg[1], w: slot_reg[2],
                  n: slot_reg[3], s: slot_reg[4]};

    swl_flux_unit u_flux (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start_reg),
        .st    (st),
        .coef  (coef_reg),
        .done  (alu_done),
        .u_new (u_new),
        .v_new (v_new),
        .h_new (h_new)
    );

    assign cmd.ready = (state_reg == swl_pkg::ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign in_grid   = int'(cmd.cell_index) < swl_pkg::CELLS;
    assign cmd_idx   = IW'(cmd.cell_index);

    // Stencil reads go out in the order center, east, west, north, south.
    always_comb
    begin
        case (ld_reg)
            3'd0:    nbr_addr = k_reg;
            3'd1:    nbr_addr = k_reg + IW'(1);
            3'd2:    nbr_addr = k_reg - IW'(1);
            3'd3:    nbr_addr = k_reg + IW'(swl_pkg::COLS);
            3'd4:    nbr_addr = k_reg - IW'(swl_pkg::COLS);
            default: nbr_addr = k_reg;
        endcase
    end

    // Edge cell and the step toward its three inner neighbors.
    always_comb
    begin
        if (!row_pass_reg)
        begin
            tgt    = side_reg ? k_reg + IW'(swl_pkg::COLS - 1) : k_reg;
            stride = side_reg ? {IW{1'b1}} : IW'(1);
        end
        else
        begin
            tgt    = side_reg ? k_reg + IW'((swl_pkg::ROWS - 1) * swl_pkg::COLS) : k_reg;
            stride = side_reg ? IW'(0) - IW'(swl_pkg::COLS) : IW'(swl_pkg::COLS);
        end
        edge_addr = (ld_reg == 3'd0) ? tgt + stride : ptr_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ld_next        = ld_reg;
        side_next      = side_reg;
        row_pass_next  = row_pass_reg;
        ptr_next       = ptr_reg;
        oob_next       = oob_reg;
        alu_start_next = 1'b0;
        out_load       = 1'b0;
        slot_shift     = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = {bank_reg, cmd_idx};
        mem_wr_uvh     = 1'b0;
        mem_wr_bed     = 1'b0;
        mem_wr_addr    = {bank_reg, cmd_idx};
        mem_wr_data    = '{u: cmd.u_in, v: cmd.v_in, h: cmd.h_in, b: cmd.b_in};

        case (state_reg)
            swl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (swl_pkg::op_t'(cmd.operation))
                        swl_pkg::OP_WRITE:
                        begin
                            mem_wr_uvh = in_grid;
                            mem_wr_bed = in_grid;
                        end
                        swl_pkg::OP_STEP:
                        begin
                            row_next   = swl_pkg::ROW_W'(1);
                            col_next   = swl_pkg::COL_W'(1);
                            k_next     = IW'(swl_pkg::COLS + 1);
                            ld_next    = '0;
                            state_next = swl_pkg::ST_CELL_LOAD;
                        end
                        swl_pkg::OP_READ:
                        begin
                            mem_rd_en  = 1'b1;
                            oob_next   = !in_grid;
                            state_next = swl_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            swl_pkg::ST_READ:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = swl_pkg::ST_IDLE;
                end
            end

            swl_pkg::ST_CELL_LOAD:
            begin
                mem_rd_en   = (ld_reg != 3'd5);
                mem_rd_addr = {bank_reg, nbr_addr};
                slot_shift  = (ld_reg != 3'd0);
                ld_next     = ld_reg + 3'd1;
                if (ld_reg == 3'd5)
                begin
                    alu_start_next = 1'b1;
                    state_next     = swl_pkg::ST_CELL_CALC;
                end
            end

            swl_pkg::ST_CELL_CALC:
            begin
                if (alu_done)
                begin
                    mem_wr_uvh  = 1'b1;
                    mem_wr_addr = {~bank_reg, k_reg};
                    mem_wr_data = '{u: u_new, v: v_new, h: h_new, b: '0};
                    ld_next     = '0;
                    state_next  = swl_pkg::ST_CELL_LOAD;
                    if (row_reg == swl_pkg::ROW_W'(swl_pkg::ROWS - 2) &&
                        col_reg == swl_pkg::COL_W'(swl_pkg::COLS - 2))
                    begin
                        // Interior done; edge columns start on the first inner row.
                        row_next      = swl_pkg::ROW_W'(1);
                        k_next        = IW'(swl_pkg::COLS);
                        side_next     = 1'b0;
                        row_pass_next = 1'b0;
                        state_next    = swl_pkg::ST_EDGE_LOAD;
                    end
                    else if (col_reg == swl_pkg::COL_W'(swl_pkg::COLS - 2))
                    begin
                        col_next = swl_pkg::COL_W'(1);
                        row_next = row_reg + swl_pkg::ROW_W'(1);
                        k_next   = k_reg + IW'(3);
                    end
                    else
                    begin
                        col_next = col_reg + swl_pkg::COL_W'(1);
                        k_next   = k_reg + IW'(1);
                    end
                end
            end

            swl_pkg::ST_EDGE_LOAD:
            begin
                mem_rd_en   = (ld_reg != 3'd3);
                mem_rd_addr = {~bank_reg, edge_addr};
                ptr_next    = edge_addr + stride;
                slot_shift  = (ld_reg != 3'd0);
                ld_next     = ld_reg + 3'd1;
                if (ld_reg == 3'd3)
                begin
                    state_next = swl_pkg::ST_EDGE_WB;
                end
            end

            swl_pkg::ST_EDGE_WB:
            begin
                mem_wr_uvh  = 1'b1;
                mem_wr_addr = {~bank_reg, tgt};
                mem_wr_data = '{u: swl_pkg::extrap(slot_reg[2].u, slot_reg[3].u, slot_reg[4].u),
                                v: swl_pkg::extrap(slot_reg[2].v, slot_reg[3].v, slot_reg[4].v),
                                h: swl_pkg::extrap(slot_reg[2].h, slot_reg[3].h, slot_reg[4].h),
                                b: '0};
                ld_next     = '0;
                side_next   = ~side_reg;
                state_next  = swl_pkg::ST_EDGE_LOAD;
                if (side_reg)
                begin
                    if (!row_pass_reg)
                    begin
                        // Edge rows are rebuilt whole below, so only inner rows get columns.
                        if (row_reg == swl_pkg::ROW_W'(swl_pkg::ROWS - 2))
                        begin
                            row_pass_next = 1'b1;
                            col_next      = '0;
                            k_next        = '0;
                        end
                        else
                        begin
                            row_next = row_reg + swl_pkg::ROW_W'(1);
                            k_next   = k_reg + IW'(swl_pkg::COLS);
                        end
                    end
                    else if (col_reg == swl_pkg::COL_W'(swl_pkg::COLS - 1))
                    begin
                        bank_next  = ~bank_reg;
                        state_next = swl_pkg::ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_reg + swl_pkg::COL_W'(1);
                        k_next   = k_reg + IW'(1);
                    end
                end
            end

            default:
            begin
                state_next = swl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swl_pkg::ST_IDLE;
            bank_reg      <= 1'b0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            ld_reg        <= '0;
            side_reg      <= 1'b0;
            row_pass_reg  <= 1'b0;
            ptr_reg       <= '0;
            oob_reg       <= 1'b0;
            alu_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ld_reg        <= ld_next;
            side_reg      <= side_next;
            row_pass_reg  <= row_pass_next;
            ptr_reg       <= ptr_next;
            oob_reg       <= oob_next;
            alu_start_reg <= alu_start_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.ax <= swl_pkg::X_ADVECT_RESET;
            coef_reg.ay <= swl_pkg::Y_ADVECT_RESET;
            coef_reg.gx <= swl_pkg::X_GRAVITY_RESET;
            coef_reg.gy <= swl_pkg::Y_GRAVITY_RESET;
        end
        else if (cfg_we)
        begin
            case (swl_pkg::cfg_sel_t'(cfg_index))
                swl_pkg::CFG_X_ADVECT:  coef_reg.ax <= cfg_data;
                swl_pkg::CFG_Y_ADVECT:  coef_reg.ay <= cfg_data;
                swl_pkg::CFG_X_GRAVITY: coef_reg.gx <= cfg_data;
                swl_pkg::CFG_Y_GRAVITY: coef_reg.gy <= cfg_data;
                default: ;
            endcase
        end
    end

    // Read data shifts in at the top, so the first read ends up in slot zero.
    always_ff @(posedge clk)
    begin
        if (slot_shift)
        begin
            for (int i = 0; i < 4; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
            slot_reg[4] <= mem_rd_data;
        end
        if (out_load)
        begin
            u_out_reg <= oob_reg ? '0 : mem_rd_data.u;
            v_out_reg <= oob_reg ? '0 : mem_rd_data.v;
            h_out_reg <= oob_reg ? '0 : mem_rd_data.h;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.u_out = u_out_reg;
    assign rsp.v_out = v_out_reg;
    assign rsp.h_out = h_out_reg;

endmodule

`default_nettype wire
